FILE: hdl/voxel_three_shear_rotate_defines.svh
// Assertion macros used by the voxel shear rotator port checker.
// Plain SystemVerilog only; no other file or package is needed.
`ifndef VOXEL_THREE_SHEAR_ROTATE_DEFINES_SVH
`define VOXEL_THREE_SHEAR_ROTATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VTSR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VTSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/vtsr_pkg.sv
// Shared types, constants and the shear schedule of the voxel shear rotator.
// Used by every module of the block; depends on nothing.
package vtsr_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT  = 12;
   localparam int GUARD_BITS         = 12;
   localparam int SHEAR_BITS         = 16;
   localparam int REG_COUNT          = 6;
   localparam int REG_INDEX_BITS     = 3;
   localparam int STEP_COUNT         = 9;
   localparam int STEP_STAGES        = 3;
   localparam int PIPE_DEPTH         = STEP_COUNT * STEP_STAGES + 1;

   // Operation carried in the request's user field.
   localparam logic OP_ROTATE = 1'b0;
   localparam logic OP_UNDO   = 1'b1;

   // Shear register indexes on the configuration port.
   typedef logic [REG_INDEX_BITS-1:0] reg_index_type;
   localparam reg_index_type REG_SHEAR_X_FIRST  = 3'd0;
   localparam reg_index_type REG_SHEAR_X_MIDDLE = 3'd1;
   localparam reg_index_type REG_SHEAR_Y_FIRST  = 3'd2;
   localparam reg_index_type REG_SHEAR_Y_MIDDLE = 3'd3;
   localparam reg_index_type REG_SHEAR_Z_FIRST  = 3'd4;
   localparam reg_index_type REG_SHEAR_Z_MIDDLE = 3'd5;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // One shear: the coordinate that moves, the one it is sheared by, the factor.
   typedef struct packed {
      axis_type      dst;
      axis_type      src;
      reg_index_type shear;
   } step_plan_type;

   // Control that travels beside each coordinate triple.
   typedef struct packed {
      logic valid;
      logic op;
      logic ovf;
   } item_ctl_type;

   // Forward rotation order; undo runs this list backwards and subtracts.
   function automatic step_plan_type step_plan(input int unsigned step);
      step_plan_type plan;
      case (step)
         0: plan = '{dst: AXIS_Y, src: AXIS_Z, shear: REG_SHEAR_X_FIRST};
         1: plan = '{dst: AXIS_Z, src: AXIS_Y, shear: REG_SHEAR_X_MIDDLE};
         2: plan = '{dst: AXIS_Y, src: AXIS_Z, shear: REG_SHEAR_X_FIRST};
         3: plan = '{dst: AXIS_X, src: AXIS_Z, shear: REG_SHEAR_Y_FIRST};
         4: plan = '{dst: AXIS_Z, src: AXIS_X, shear: REG_SHEAR_Y_MIDDLE};
         5: plan = '{dst: AXIS_X, src: AXIS_Z, shear: REG_SHEAR_Y_FIRST};
         6: plan = '{dst: AXIS_X, src: AXIS_Y, shear: REG_SHEAR_Z_FIRST};
         7: plan = '{dst: AXIS_Y, src: AXIS_X, shear: REG_SHEAR_Z_MIDDLE};
         8: plan = '{dst: AXIS_X, src: AXIS_Y, shear: REG_SHEAR_Z_FIRST};
         default: plan = '{dst: AXIS_X, src: AXIS_Y, shear: REG_SHEAR_X_FIRST};
      endcase
      return plan;
   endfunction

endpackage

FILE: hdl/vtsr_shear_step.sv
// One shear of the rotation as three register stages: multiply, round, add and clamp.
// Depends on vtsr_pkg for the shear schedule and the control struct.
module vtsr_shear_step #(
   parameter int COORD_BITS = vtsr_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = vtsr_pkg::FRAC_BITS_DEFAULT,
   parameter int STEP       = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  vtsr_pkg::item_ctl_type       up_ctl,
   input  logic [2:0][COORD_BITS+vtsr_pkg::GUARD_BITS-1:0] up_coord,
   output logic                         up_ready,
   input  logic [vtsr_pkg::REG_COUNT-1:0][vtsr_pkg::SHEAR_BITS-1:0] shear_regs,
   output vtsr_pkg::item_ctl_type       down_ctl,
   output logic [2:0][COORD_BITS+vtsr_pkg::GUARD_BITS-1:0] down_coord,
   input  logic                         down_ready
);

   localparam int W  = COORD_BITS + vtsr_pkg::GUARD_BITS;
   localparam int PW = W + 1 + vtsr_pkg::SHEAR_BITS;
   localparam int TW = PW - FRAC_BITS - 1;
   localparam int VW = ((W > TW) ? W : TW) + 1;
   localparam vtsr_pkg::step_plan_type FWD_PLAN = vtsr_pkg::step_plan(STEP);
   localparam vtsr_pkg::step_plan_type REV_PLAN =
      vtsr_pkg::step_plan(vtsr_pkg::STEP_COUNT - 1 - STEP);
   localparam logic [PW-1:0] HALF_LSB = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic rdy1, rdy2, rdy3;

   vtsr_pkg::item_ctl_type ctl1_ff, ctl1_in, ctl2_ff, ctl2_in, ctl3_ff, ctl3_in;
   logic [2:0][W-1:0] coord1_ff, coord1_in, coord2_ff, coord2_in, coord3_ff, coord3_in;
   logic signed [PW-1:0] prod1_ff, prod1_in;
   logic [TW-1:0] term2_ff, term2_in;

   vtsr_pkg::step_plan_type plan1, plan3;
   logic signed [W:0]   odd1;
   logic signed [vtsr_pkg::SHEAR_BITS-1:0] shear1;
   logic [PW-1:0]       rnd2;
   logic signed [W-1:0] base3;
   logic signed [VW-1:0] sum3;
   logic [VW-W:0]       high3;
   logic                in_range3;
   logic [W-1:0]        clamp3;

   // Ready flows back stage by stage so bubbles collapse.
   assign rdy3     = !ctl3_ff.valid || down_ready;
   assign rdy2     = !ctl2_ff.valid || rdy3;
   assign rdy1     = !ctl1_ff.valid || rdy2;
   assign up_ready = rdy1;

   // Stage 1: pick the source coordinate and factor, form (2c+1)*shear.
   always_comb begin
      plan1     = (up_ctl.op == vtsr_pkg::OP_UNDO) ? REV_PLAN : FWD_PLAN;
      odd1      = $signed({up_coord[plan1.src], 1'b1});
      shear1    = $signed(shear_regs[plan1.shear]);
      prod1_in  = PW'(odd1) * PW'(shear1);
      ctl1_in   = up_ctl;
      coord1_in = up_coord;
   end

   // Stage 2: round half away from zero and drop the fraction.
   // For a negative product, adding half minus one before the floor shift
   // gives the same result as rounding the magnitude.
   always_comb begin
      rnd2      = prod1_ff + HALF_LSB - {{(PW-1){1'b0}}, prod1_ff[PW-1]};
      term2_in  = rnd2[PW-1:FRAC_BITS+1];
      ctl2_in   = ctl1_ff;
      coord2_in = coord1_ff;
   end

   // Stage 3: add or subtract the term and clamp to the intermediate range.
   always_comb begin
      plan3     = (ctl2_ff.op == vtsr_pkg::OP_UNDO) ? REV_PLAN : FWD_PLAN;
      base3     = $signed(coord2_ff[plan3.dst]);
      if (ctl2_ff.op == vtsr_pkg::OP_UNDO) begin
         sum3 = VW'(base3) - VW'($signed(term2_ff));
      end else begin
         sum3 = VW'(base3) + VW'($signed(term2_ff));
      end
      high3     = sum3[VW-1:W-1];
      in_range3 = (&high3) || !(|high3);
      if (in_range3) begin
         clamp3 = sum3[W-1:0];
      end else begin
         clamp3 = sum3[VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      coord3_in              = coord2_ff;
      coord3_in[plan3.dst]   = clamp3;
      ctl3_in                = ctl2_ff;
      ctl3_in.ovf            = ctl2_ff.ovf || !in_range3;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         if (rdy1) begin
            ctl1_ff <= ctl1_in;
         end
         if (rdy2) begin
            ctl2_ff <= ctl2_in;
         end
         if (rdy3) begin
            ctl3_ff <= ctl3_in;
         end
      end
   end

   // Payload registers move with their stage's control.
   always_ff @(posedge clock) begin
      if (rdy1) begin
         coord1_ff <= coord1_in;
         prod1_ff  <= prod1_in;
      end
      if (rdy2) begin
         coord2_ff <= coord2_in;
         term2_ff  <= term2_in;
      end
      if (rdy3) begin
         coord3_ff <= coord3_in;
      end
   end

   assign down_ctl   = ctl3_ff;
   assign down_coord = coord3_ff;

endmodule

FILE: hdl/vtsr_out_stage.sv
// Final clamp to the coordinate width and the response output register.
// Depends on vtsr_pkg for the control struct and the guard width.
module vtsr_out_stage #(
   parameter int COORD_BITS = vtsr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vtsr_pkg::item_ctl_type up_ctl,
   input  logic [2:0][COORD_BITS+vtsr_pkg::GUARD_BITS-1:0] up_coord,
   output logic                   up_ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [((3*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   localparam int W       = COORD_BITS + vtsr_pkg::GUARD_BITS;
   localparam int TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8;

   logic                     valid_ff, valid_in;
   logic                     ovf_ff, ovf_in;
   logic [2:0][COORD_BITS-1:0] coord_ff, coord_in;
   logic [2:0]               in_range;

   assign up_ready = !valid_ff || rsp_tready;

   // Clamp each coordinate to the output range.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_range[i] = (&up_coord[i][W-1:COORD_BITS-1]) || !(|up_coord[i][W-1:COORD_BITS-1]);
         if (in_range[i]) begin
            coord_in[i] = up_coord[i][COORD_BITS-1:0];
         end else if (up_coord[i][W-1]) begin
            coord_in[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
         end else begin
            coord_in[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
         end
      end
      valid_in = up_ctl.valid;
      ovf_in   = up_ctl.ovf || !(&in_range);
   end

   // Output valid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (up_ready) begin
         coord_ff <= coord_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = TDATA_W'(coord_ff);
   assign rsp_tuser  = ovf_ff;

endmodule

FILE: hdl/voxel_three_shear_rotate.sv
// Voxel rotator: signed coordinate triples enter and leave rotated (or unrotated)
// in order. The rate is one request per cycle while the response side does not
// stall; the pipeline is nine shear steps of three register stages each
// (multiply, round, add and clamp) plus the output register. Software writes the
// six shear factors over the csr port while the block is idle. No clearing pass
// is needed after reset.
// Depends on vtsr_pkg, vtsr_shear_step and vtsr_out_stage.
module voxel_three_shear_rotate #(
   parameter int COORD_BITS = vtsr_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = vtsr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // Request channel.
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,  // pos_x, pos_y, pos_z, zero pad
   input  logic req_tuser,                               // op
   // Response channel.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [((3*COORD_BITS+7)/8)*8-1:0] rsp_tdata,  // new_x, new_y, new_z, zero pad
   output logic rsp_tuser,                               // overflow
   // Configuration write channel.
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [vtsr_pkg::REG_INDEX_BITS-1:0] csr_index,
   input  logic [vtsr_pkg::SHEAR_BITS-1:0]     csr_data
);

   localparam int W = COORD_BITS + vtsr_pkg::GUARD_BITS;
   localparam int N = vtsr_pkg::STEP_COUNT;

   logic [vtsr_pkg::REG_COUNT-1:0][vtsr_pkg::SHEAR_BITS-1:0] shear_ff, shear_in;

   vtsr_pkg::item_ctl_type stage_ctl   [N+1];
   logic [2:0][W-1:0]      stage_coord [N+1];
   logic                   stage_ready [N+1];

   // Shear factor registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      shear_in = shear_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            vtsr_pkg::REG_SHEAR_X_FIRST:  shear_in[vtsr_pkg::REG_SHEAR_X_FIRST]  = csr_data;
            vtsr_pkg::REG_SHEAR_X_MIDDLE: shear_in[vtsr_pkg::REG_SHEAR_X_MIDDLE] = csr_data;
            vtsr_pkg::REG_SHEAR_Y_FIRST:  shear_in[vtsr_pkg::REG_SHEAR_Y_FIRST]  = csr_data;
            vtsr_pkg::REG_SHEAR_Y_MIDDLE: shear_in[vtsr_pkg::REG_SHEAR_Y_MIDDLE] = csr_data;
            vtsr_pkg::REG_SHEAR_Z_FIRST:  shear_in[vtsr_pkg::REG_SHEAR_Z_FIRST]  = csr_data;
            vtsr_pkg::REG_SHEAR_Z_MIDDLE: shear_in[vtsr_pkg::REG_SHEAR_Z_MIDDLE] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shear_ff <= '0;
      end else begin
         shear_ff <= shear_in;
      end
   end

   // Unpack the request and widen the coordinates to the guarded width.
   always_comb begin
      stage_ctl[0].valid = req_tvalid;
      stage_ctl[0].op    = req_tuser;
      stage_ctl[0].ovf   = 1'b0;
      stage_coord[0][0]  = W'($signed(req_tdata[COORD_BITS-1:0]));
      stage_coord[0][1]  = W'($signed(req_tdata[2*COORD_BITS-1:COORD_BITS]));
      stage_coord[0][2]  = W'($signed(req_tdata[3*COORD_BITS-1:2*COORD_BITS]));
   end

   assign req_tready = stage_ready[0];

   // Nine shear steps in a row.
   for (genvar s = 0; s < N; s++) begin : g_step
      vtsr_shear_step #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS),
         .STEP       (s)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .up_ctl     (stage_ctl[s]),
         .up_coord   (stage_coord[s]),
         .up_ready   (stage_ready[s]),
         .shear_regs (shear_ff),
         .down_ctl   (stage_ctl[s+1]),
         .down_coord (stage_coord[s+1]),
         .down_ready (stage_ready[s+1])
      );
   end

   // Final clamp and response register.
   vtsr_out_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .up_ctl     (stage_ctl[N]),
      .up_coord   (stage_coord[N]),
      .up_ready   (stage_ready[N]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: hdl/vtsr_checker.sv
// Port-level checks of the voxel rotator, bound to the top level below.
// Depends on vtsr_pkg and the assertion macros header.
`include "voxel_three_shear_rotate_defines.svh"

module vtsr_checker #(
   parameter int COORD_BITS = vtsr_pkg::COORD_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input logic req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((3*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic rsp_tuser,
   input logic csr_valid,
   input logic csr_ready,
   input logic [vtsr_pkg::REG_INDEX_BITS-1:0] csr_index,
   input logic [vtsr_pkg::SHEAR_BITS-1:0]     csr_data
);

   localparam logic [7:0] DEPTH = 8'(vtsr_pkg::PIPE_DEPTH);

   logic [7:0] outstanding_ff, outstanding_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Count requests taken but not yet answered.
   always_comb begin
      outstanding_in = outstanding_ff + {7'd0, req_fire} - {7'd0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 8'd0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // A stalled response holds its payload.
   `VTSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // Every response answers a request still in flight.
   `VTSR_ASSERT_IMPLIES(a_no_spurious, clock, reset, rsp_tvalid, outstanding_ff != 8'd0, "response without an outstanding request")

   // With the output register empty the whole pipeline can move.
   `VTSR_ASSERT_IMPLIES(a_drain_ready, clock, reset, !rsp_tvalid, req_tready, "request side blocked while output is empty")

   // The pipeline never holds more requests than it has stages.
   `VTSR_ASSERT_IMPLIES(a_bounded, clock, reset, 1'b1, outstanding_ff <= DEPTH, "more requests in flight than pipeline stages")

endmodule

bind voxel_three_shear_rotate vtsr_checker #(.COORD_BITS(COORD_BITS)) u_vtsr_checker (.*);

FILE: verif/voxel_three_shear_rotate_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the voxel shear rotator: it watches the request, response and
// shear-register channels, predicts every rotated triple and compares it.
// Depends on vtsr_pkg for the register indexes, the axis names and the operations.
module voxel_three_shear_rotate_checker
   import vtsr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [((3*COORD_BITS_DEFAULT+7)/8)*8-1:0] req_tdata,  // pos_x, pos_y, pos_z
   input  logic req_tuser,                                       // op
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [((3*COORD_BITS_DEFAULT+7)/8)*8-1:0] rsp_tdata,  // new_x, new_y, new_z
   input  logic rsp_tuser,                                       // overflow
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [REG_INDEX_BITS-1:0] csr_index,
   input  logic [SHEAR_BITS-1:0]     csr_data,
   output int   failure_count,
   output int   pending_count
);

   localparam int CW   = COORD_BITS_DEFAULT;
   localparam int FRAC = FRAC_BITS_DEFAULT;

   typedef struct packed {
      logic signed [CW-1:0] new_x;
      logic signed [CW-1:0] new_y;
      logic signed [CW-1:0] new_z;
      logic                 overflow;
   } voxel_result_type;

   // Shadow copy of the six shear factors.
   logic signed [SHEAR_BITS-1:0] shear_reg [0:REG_COUNT-1];
   voxel_result_type rotated_q [$];
   int failures = 0;

   // Clamp a value to a signed range of the given width.
   function automatic longint clamp_signed(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Displacement of one shear: (2c+1)*s / 2^(FRAC+1), rounded half away from zero.
   function automatic longint shear_offset(input longint c, input longint s);
      longint p;
      longint m;
      longint q;
      p = (2 * c + 1) * s;
      m = (p < 0) ? -p : p;
      q = (m + (longint'(1) <<< FRAC)) >>> (FRAC + 1);
      return (p < 0) ? -q : q;
   endfunction

   // Runs the nine shears forward, or backward with subtraction for undo.
   function automatic voxel_result_type rotate_voxel(input logic op,
                                                    input logic signed [CW-1:0] px,
                                                    input logic signed [CW-1:0] py,
                                                    input logic signed [CW-1:0] pz);
      longint           c [0:2];
      longint           sum;
      longint           lim;
      axis_type         dst;
      axis_type         src;
      reg_index_type    ridx;
      int               step;
      bit               ovf;
      voxel_result_type res;
      c[AXIS_X] = px;
      c[AXIS_Y] = py;
      c[AXIS_Z] = pz;
      ovf = 1'b0;
      dst = AXIS_X;
      src = AXIS_Y;
      ridx = REG_SHEAR_X_FIRST;
      for (int k = 0; k < 9; k++) begin
         step = (op == OP_UNDO) ? 8 - k : k;
         case (step)
            0: begin dst = AXIS_Y; src = AXIS_Z; ridx = REG_SHEAR_X_FIRST;  end
            1: begin dst = AXIS_Z; src = AXIS_Y; ridx = REG_SHEAR_X_MIDDLE; end
            2: begin dst = AXIS_Y; src = AXIS_Z; ridx = REG_SHEAR_X_FIRST;  end
            3: begin dst = AXIS_X; src = AXIS_Z; ridx = REG_SHEAR_Y_FIRST;  end
            4: begin dst = AXIS_Z; src = AXIS_X; ridx = REG_SHEAR_Y_MIDDLE; end
            5: begin dst = AXIS_X; src = AXIS_Z; ridx = REG_SHEAR_Y_FIRST;  end
            6: begin dst = AXIS_X; src = AXIS_Y; ridx = REG_SHEAR_Z_FIRST;  end
            7: begin dst = AXIS_Y; src = AXIS_X; ridx = REG_SHEAR_Z_MIDDLE; end
            default: begin dst = AXIS_X; src = AXIS_Y; ridx = REG_SHEAR_Z_FIRST; end
         endcase
         sum = (op == OP_UNDO) ? c[dst] - shear_offset(c[src], shear_reg[ridx])
                               : c[dst] + shear_offset(c[src], shear_reg[ridx]);
         // Intermediate values live in the guarded width.
         lim = clamp_signed(sum, CW + GUARD_BITS);
         if (lim != sum) ovf = 1'b1;
         c[dst] = lim;
      end
      // Final clamp to the coordinate width.
      for (int a = 0; a < 3; a++) begin
         lim = clamp_signed(c[a], CW);
         if (lim != c[a]) ovf = 1'b1;
         c[a] = lim;
      end
      res.new_x = c[AXIS_X][CW-1:0];
      res.new_y = c[AXIS_Y][CW-1:0];
      res.new_z = c[AXIS_Z][CW-1:0];
      res.overflow = ovf;
      return res;
   endfunction

   always @(posedge clock) begin : scoreboard
      voxel_result_type want;
      if (reset) begin
         rotated_q.delete();
         for (int i = 0; i < REG_COUNT; i++) shear_reg[i] = '0;
      end else begin
         // Compare each response with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (rotated_q.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = rotated_q.pop_front();
               if (rsp_tdata[CW-1:0] !== want.new_x) begin
                  $error("new_x: expected %0d, actual %0d",
                         want.new_x, $signed(rsp_tdata[CW-1:0]));
                  failures++;
               end
               if (rsp_tdata[2*CW-1:CW] !== want.new_y) begin
                  $error("new_y: expected %0d, actual %0d",
                         want.new_y, $signed(rsp_tdata[2*CW-1:CW]));
                  failures++;
               end
               if (rsp_tdata[3*CW-1:2*CW] !== want.new_z) begin
                  $error("new_z: expected %0d, actual %0d",
                         want.new_z, $signed(rsp_tdata[3*CW-1:2*CW]));
                  failures++;
               end
               if (rsp_tuser !== want.overflow) begin
                  $error("overflow: expected %0d, actual %0d", want.overflow, rsp_tuser);
                  failures++;
               end
            end
         end
         // Predict each accepted request with the factors in force now.
         if (req_tvalid && req_tready)
            rotated_q = {rotated_q, rotate_voxel(req_tuser, req_tdata[CW-1:0],
                                                 req_tdata[2*CW-1:CW],
                                                 req_tdata[3*CW-1:2*CW])};
         // Writes to indexes past the last register are ignored.
         if (csr_valid && csr_ready && csr_index < REG_COUNT)
            shear_reg[csr_index] = csr_data;
      end
      pending_count <= rotated_q.size();
      failure_count <= failures;
   end

endmodule

FILE: verif/voxel_three_shear_rotate_tb.sv
`timescale 1ns / 1ps
// Top of the voxel shear rotator testbench: clock, reset, stimulus and verdict.
// Depends on vtsr_pkg, the block itself and voxel_three_shear_rotate_checker.
module voxel_three_shear_rotate_tb;
   import vtsr_pkg::*;

   localparam int CW            = COORD_BITS_DEFAULT;
   localparam int DW            = ((3*CW+7)/8)*8;
   localparam int NUM_PHASES    = 10;
   localparam int RANDOM_ITEMS  = 100;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int IDLE_PERCENT  = 27;
   localparam logic [CW-1:0] COORD_MAX = 16'h7FFF;
   localparam logic [CW-1:0] COORD_MIN = 16'h8000;
   localparam logic [SHEAR_BITS-1:0] SHEAR_MAX = 16'h7FFF;
   localparam logic [SHEAR_BITS-1:0] SHEAR_MIN = 16'h8000;
   localparam logic [SHEAR_BITS-1:0] SHEAR_ONE = 16'd4096;
   localparam reg_index_type UNUSED_INDEX = 3'd7;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;   // pos_x, pos_y, pos_z
   logic req_tuser = OP_ROTATE;     // op
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;        // new_x, new_y, new_z
   logic rsp_tuser;                 // overflow
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [REG_INDEX_BITS-1:0] csr_index = '0;
   logic [SHEAR_BITS-1:0]     csr_data = '0;

   int failure_count;
   int pending_count;
   int cycles = 0;
   bit steady = 1'b0;
   logic [SHEAR_BITS-1:0] shear_plan [0:REG_COUNT-1];

   voxel_three_shear_rotate uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   voxel_three_shear_rotate_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .failure_count(failure_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side stalls at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Writes the planned factors, optionally followed by a write to an unused index.
   task automatic program_shears(input bit poke_unused);
      int count;
      count = REG_COUNT + (poke_unused ? 1 : 0);
      for (int k = 0; k < count; k++) begin
         csr_valid <= 1'b1;
         csr_index <= (k < REG_COUNT) ? reg_index_type'(k) : UNUSED_INDEX;
         csr_data  <= (k < REG_COUNT) ? shear_plan[k] : 16'hA5A5;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Offers one request, with a random gap before it unless in the steady stretch.
   task automatic send_request(input logic op, input logic [CW-1:0] px,
                               input logic [CW-1:0] py, input logic [CW-1:0] pz);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pz, py, px};
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits until every predicted result has come back, then lets the pipe settle.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] random_coord();
      logic [CW-1:0] v;
      // Half full range, half near the origin.
      if ($urandom_range(1)) v = CW'($urandom_range(16'hFFFF));
      else v = CW'($urandom_range(2048) - 1024);
      return v;
   endfunction

   function automatic logic [SHEAR_BITS-1:0] random_shear(input bit full_range);
      logic [SHEAR_BITS-1:0] v;
      if (full_range) v = SHEAR_BITS'($urandom_range(16'hFFFF));
      else v = SHEAR_BITS'($urandom_range(2 * SHEAR_ONE) - SHEAR_ONE);
      return v;
   endfunction

   initial begin : stimulus
      logic [CW-1:0] dx, dy, dz;
      logic          dop;
      int            directed;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < NUM_PHASES; p++) begin
         // Phase zero keeps the reset factors, which must leave triples unchanged.
         if (p > 0) begin
            for (int r = 0; r < REG_COUNT; r++) begin
               case (p)
                  1: shear_plan[r] = (r % 2 == 0) ? -SHEAR_ONE : SHEAR_ONE;
                  2: shear_plan[r] = SHEAR_MAX;
                  3: shear_plan[r] = SHEAR_MIN;
                  default: shear_plan[r] = random_shear(p % 2 == 0);
               endcase
            end
            program_shears(p == 3);
         end
         steady = (p == 6);

         // Coordinate extremes under identity, quarter turns and extreme factors.
         directed = (p < 2) ? 6 : (p < 4) ? 4 : 0;
         for (int k = 0; k < directed; k++) begin
            case (k)
               0: begin dop = OP_ROTATE; dx = '0; dy = '0; dz = '0; end
               1: begin dop = OP_UNDO; dx = '0; dy = '0; dz = '0; end
               2: begin dop = OP_ROTATE; dx = COORD_MAX; dy = COORD_MAX; dz = COORD_MAX; end
               3: begin dop = OP_UNDO; dx = COORD_MIN; dy = COORD_MIN; dz = COORD_MIN; end
               4: begin dop = OP_ROTATE; dx = COORD_MAX; dy = COORD_MIN; dz = COORD_MAX; end
               default: begin dop = OP_UNDO; dx = '1; dy = 16'd1; dz = '1; end
            endcase
            send_request(dop, dx, dy, dz);
         end

         for (int k = 0; k < RANDOM_ITEMS; k++) begin
            dop = $urandom_range(1) ? OP_UNDO : OP_ROTATE;
            send_request(dop, random_coord(), random_coord(), random_coord());
         end
         req_tvalid <= 1'b0;
         wait_drained();
      end

      if (failure_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: voxel_three_shear_rotate.f
+incdir+hdl
hdl/vtsr_pkg.sv
hdl/vtsr_shear_step.sv
hdl/vtsr_out_stage.sv
hdl/voxel_three_shear_rotate.sv
hdl/vtsr_checker.sv
verif/voxel_three_shear_rotate_checker.sv
verif/voxel_three_shear_rotate_tb.sv
